// File: hw/rtl/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and helpers for the base64 stream decoder
// Job record passed from the front end to the back end, alphabet decode.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SextetW = 6;
  localparam int unsigned WordW   = 3 * ByteW;
  localparam int unsigned AccW    = 3 * SextetW;

  localparam logic [ByteW-1:0] ChUpperA = 8'h41;
  localparam logic [ByteW-1:0] ChUpperZ = 8'h5a;
  localparam logic [ByteW-1:0] ChLowerA = 8'h61;
  localparam logic [ByteW-1:0] ChLowerZ = 8'h7a;
  localparam logic [ByteW-1:0] ChDigit0 = 8'h30;
  localparam logic [ByteW-1:0] ChDigit9 = 8'h39;
  localparam logic [ByteW-1:0] ChPlus   = 8'h2b;
  localparam logic [ByteW-1:0] ChSlash  = 8'h2f;

  localparam logic [ByteW-1:0] LowerOfs = 8'd71;  // 'a' - 26
  localparam logic [ByteW-1:0] DigitAdd = 8'd4;   // 52 - '0'
  localparam logic [SextetW-1:0] PlusVal  = 6'd62;
  localparam logic [SextetW-1:0] SlashVal = 6'd63;

  // One unit of work for the back end: up to three bytes, optional end mark.
  typedef struct packed {
    logic [WordW-1:0] word;    // bytes, first one in the top bits
    logic [1:0]       nbytes;  // 0..3 bytes due
    logic             eos;     // string closes with this job
  } b64d_job_t;

  typedef struct packed {
    logic               hit;
    logic [SextetW-1:0] val;
  } b64d_sextet_t;

  function automatic b64d_sextet_t sextet_of(input logic [ByteW-1:0] c);
    b64d_sextet_t r;
    logic [ByteW-1:0] t;
    r.hit = 1'b1;
    t     = '0;
    case (c) inside
      [ChUpperA:ChUpperZ]: t = c - ChUpperA;
      [ChLowerA:ChLowerZ]: t = c - LowerOfs;
      [ChDigit0:ChDigit9]: t = c + DigitAdd;
      ChPlus:              t = {2'b00, PlusVal};
      ChSlash:             t = {2'b00, SlashVal};
      default:             r.hit = 1'b0;
    endcase
    r.val = t[SextetW-1:0];
    return r;
  endfunction

endpackage

// File: hw/rtl/b64d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front: character intake and sextet gathering
// Maps each character, keeps the pending group, emits byte jobs.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           char_code_i,
  input  logic                 last_char_i,
  input  logic                 full_i,
  output logic                 push_o,
  output b64d_pkg::b64d_job_t  job_o
);
  import b64d_pkg::*;

  logic [AccW-1:0] acc_q, acc_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            stop_q, stop_d;
  logic            accept;
  b64d_sextet_t    sx;
  b64d_job_t       job;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign sx         = sextet_of(char_code_i);

  always_comb begin
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    stop_d     = stop_q;
    job.word   = '0;
    job.nbytes = 2'd0;
    job.eos    = 1'b0;
    if (!stop_q) begin
      if (!sx.hit) begin
        stop_d = 1'b1;
      end else if (cnt_q == 2'd3) begin
        job.word   = {acc_q, sx.val};
        job.nbytes = 2'd3;
        acc_d      = '0;
        cnt_d      = 2'd0;
      end else begin
        acc_d = {acc_q[AccW-SextetW-1:0], sx.val};
        cnt_d = cnt_q + 2'd1;
      end
    end
    if (last_char_i) begin
      // flush a partial group, zero padded
      if (cnt_d == 2'd2) begin
        job.word   = {acc_d[2*SextetW-1:0], {(WordW-2*SextetW){1'b0}}};
        job.nbytes = 2'd1;
      end else if (cnt_d == 2'd3) begin
        job.word   = {acc_d, {(WordW-AccW){1'b0}}};
        job.nbytes = 2'd2;
      end
      job.eos = 1'b1;
      acc_d   = '0;
      cnt_d   = 2'd0;
      stop_d  = 1'b0;
    end
  end

  assign push_o = accept && ((job.nbytes != 2'd0) || job.eos);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= 2'd0;
      stop_q <= 1'b0;
    end else if (accept) begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      stop_q <= stop_d;
    end
  end

endmodule

// File: hw/rtl/b64d_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_job_fifo: job queue between front and back end
// Small circular buffer; head entry is shown while not empty.
// ----------------------------------------------------------------------------
module b64d_job_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  b64d_pkg::b64d_job_t  job_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output b64d_pkg::b64d_job_t  head_o
);
  import b64d_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

  b64d_job_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    if (pop_i)  rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into full queue");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt)
    else $error("queue fill count out of range");

endmodule

// File: hw/rtl/b64d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back: result sequencer
// Walks the head job one result per cycle into the output register while the receiver takes them.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  b64d_pkg::b64d_job_t  job_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           data_byte_o,
  output logic                 byte_present_o,
  output logic                 last_of_run_o,
  output logic                 end_of_string_o
);
  import b64d_pkg::*;

  logic [1:0]       idx_q, idx_d;
  logic             vld_q, vld_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             pres_q, last_q, eos_q;
  logic             pres_d, last_d, eos_d;
  logic             load, last_res;

  assign load     = (!vld_q || out_ready_i) && !empty_i;
  assign last_res = (job_i.nbytes == 2'd0) || (idx_q == job_i.nbytes - 2'd1);
  assign pop_o    = load && last_res;

  always_comb begin
    case (idx_q)
      2'd0:    byte_d = job_i.word[WordW-1 -: ByteW];
      2'd1:    byte_d = job_i.word[WordW-ByteW-1 -: ByteW];
      default: byte_d = job_i.word[ByteW-1:0];
    endcase
    pres_d = (job_i.nbytes != 2'd0);
    if (!pres_d) byte_d = '0;
    last_d = last_res;
    eos_d  = last_res && job_i.eos;
    idx_d  = idx_q;
    if (load) idx_d = last_res ? 2'd0 : idx_q + 2'd1;
    vld_d = load ? 1'b1 : (out_ready_i ? 1'b0 : vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      pres_q <= pres_d;
      last_q <= last_d;
      eos_q  <= eos_d;
    end
  end

  assign out_valid_o     = vld_q;
  assign data_byte_o     = byte_q;
  assign byte_present_o  = pres_q;
  assign last_of_run_o   = last_q;
  assign end_of_string_o = eos_q;

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("pop from empty queue");

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd3)
    else $error("byte index out of range");

  a_marker_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !pres_q) |-> (byte_q == '0) && eos_q && last_q)
    else $error("end marker malformed");

  a_eos_closes_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && eos_q) |-> last_q)
    else $error("end of string not on last result of item");

endmodule

// File: hw/rtl/base64_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming base64 decoder, one character per item
// Front end gathers sextets, job queue, back end emits one byte per result.
// ----------------------------------------------------------------------------
// Feed one ASCII character per input item with last_char_i set on the
// final character of each string. Every fourth alphabet character yields
// three byte results; the first character outside the alphabet ('=' too)
// stops decoding until the end of the string, where a partial group of k
// values yields k-1 bytes. Each string closes with a result flagged
// end_of_string_o, a bare marker (byte_present_o low) if no byte is due.
// last_of_run_o marks the final result caused by one input item. Input is
// taken one item per cycle while the job queue has room; the back end
// delivers one result per cycle while the receiver takes them, and the
// queue absorbs the burst of a character yielding three bytes. An accepted
// item's job is written into the job queue, and its first result is
// loaded into the output register from the queue head once that register
// is free and earlier jobs have drained.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       byte_present_o,
  output logic       last_of_run_o,
  output logic       end_of_string_o
);
  import b64d_pkg::*;

  logic      push, pop, full, empty;
  b64d_job_t job_in, job_head;

  // classify characters and build byte jobs
  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (job_in)
  );

  // decouple intake from result delivery
  b64d_job_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (job_head)
  );

  // drain each job one result at a time
  b64d_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .job_i           (job_head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .data_byte_o     (data_byte_o),
    .byte_present_o  (byte_present_o),
    .last_of_run_o   (last_of_run_o),
    .end_of_string_o (end_of_string_o)
  );

endmodule

// File: tb/tb_base64_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder: self-checking bench for the base64 stream decoder
// Feeds directed and random character strings through the valid/ready input.
// A local decoder predicts each byte result and end marker, and every output
// item is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder;

  // Give up after this many cycles with no item moving on either side.
  localparam int IdleLimit   = 2000;
  // Long receiver hold-off used to fill the decoder's job queue.
  localparam int HoldCycles  = 80;
  // Margin after the last predicted result is taken, before the bench reports.
  localparam int DrainCycles = 8;
  localparam int RandomChars = 240;
  localparam int PressureChars = 45;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_of_run;
    logic       end_of_string;
  } byte_result_t;

  typedef enum logic [1:0] {
    ReadyAlways,
    ReadyRandom,
    ReadyPattern
  } ready_mode_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] char_code_i = 8'h00;
  logic       last_char_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] data_byte_o;
  logic       byte_present_o;
  logic       last_of_run_o;
  logic       end_of_string_o;

  base64_stream_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code_i),
    .last_char_i    (last_char_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_byte_o    (data_byte_o),
    .byte_present_o (byte_present_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_string_o(end_of_string_o)
  );

  always #1 clk_i = ~clk_i;

  // Decoder state as the bench sees it: pending sextets, count, stop flag.
  logic [17:0] sextets_pending = '0;
  logic [1:0]  sextet_total    = '0;
  logic        decode_halted   = 1'b0;

  byte_result_t expected_bytes_q[$];

  int errors          = 0;
  int chars_accepted  = 0;
  int strings_closed  = 0;
  int bytes_checked   = 0;
  int markers_checked = 0;
  int idle_cycles     = 0;

  // Sender burst bookkeeping and receiver hold-off handshake.
  int burst_left    = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  // Six-bit value of an alphabet character, or -1 for anything else.
  function automatic int sextet_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  // Alphabet character that carries a given six-bit value.
  function automatic logic [7:0] alphabet_char(input int v);
    if (v < 26) return 8'(int'("A") + v);
    if (v < 52) return 8'(int'("a") + v - 26);
    if (v < 62) return 8'(int'("0") + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  // Work out the results one accepted character causes and queue them.
  function automatic void predict_decoded_bytes(input logic [7:0] c, input logic last_c);
    byte_result_t run[$];
    byte_result_t r;
    logic [23:0]  word;
    int           v;
    if (!decode_halted) begin
      v = sextet_value(c);
      if (v < 0) begin
        decode_halted = 1'b1;
      end else if (sextet_total == 2'd3) begin
        // Fourth value completes a group: three bytes, first from the top.
        word = {sextets_pending, 6'(v)};
        run.push_back('{word[23:16], 1'b1, 1'b0, 1'b0});
        run.push_back('{word[15:8], 1'b1, 1'b0, 1'b0});
        run.push_back('{word[7:0], 1'b1, 1'b0, 1'b0});
        sextets_pending = '0;
        sextet_total    = '0;
      end else begin
        sextets_pending = {sextets_pending[11:0], 6'(v)};
        sextet_total    = sextet_total + 2'd1;
      end
    end
    if (last_c) begin
      // Zero-pad a partial group; k values give k-1 bytes.
      if (sextet_total >= 2'd2) begin
        word = {sextets_pending, 6'b0} << (6 * (3 - int'(sextet_total)));
        run.push_back('{word[23:16], 1'b1, 1'b0, 1'b0});
        if (sextet_total == 2'd3) run.push_back('{word[15:8], 1'b1, 1'b0, 1'b0});
      end
      if (run.size() == 0) run.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
      r = run.pop_back();
      r.end_of_string = 1'b1;
      run.push_back(r);
      sextets_pending = '0;
      sextet_total    = '0;
      decode_halted   = 1'b0;
    end
    if (run.size() > 0) begin
      r = run.pop_back();
      r.last_of_run = 1'b1;
      run.push_back(r);
    end
    foreach (run[i]) expected_bytes_q.push_back(run[i]);
  endfunction

  // Predict on every accepted character, check every accepted result, and
  // watch for a stuck interface.
  always @(posedge clk_i) begin
    byte_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_decoded_bytes(char_code_i, last_char_i);
        chars_accepted++;
        if (last_char_i) strings_closed++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_bytes_q.size() == 0) begin
          $error("unexpected result: data_byte=%02h byte_present=%0b", data_byte_o,
                 byte_present_o);
          errors++;
        end else begin
          want = expected_bytes_q.pop_front();
          if (data_byte_o !== want.data_byte) begin
            $error("data_byte: expected %02h, got %02h", want.data_byte, data_byte_o);
            errors++;
          end
          if (byte_present_o !== want.byte_present) begin
            $error("byte_present: expected %0b, got %0b", want.byte_present,
                   byte_present_o);
            errors++;
          end
          if (last_of_run_o !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, last_of_run_o);
            errors++;
          end
          if (end_of_string_o !== want.end_of_string) begin
            $error("end_of_string: expected %0b, got %0b", want.end_of_string,
                   end_of_string_o);
            errors++;
          end
          if (want.byte_present) bytes_checked++;
          else markers_checked++;
        end
      end
      // Count cycles where nothing moved; bail out if the block hangs.
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("Timeout: no item moved for %0d cycles", IdleLimit);
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // Receiver: switch between always-ready, random and a rotating pattern;
  // a pending hold-off request overrides all of them.
  ready_mode_e ready_mode  = ReadyAlways;
  int          mode_left   = 0;
  logic [7:0]  ready_bits  = 8'hff;
  int          ready_phase = 0;

  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 2));
        mode_left  = $urandom_range(16, 80);
        ready_bits = 8'($urandom_range(0, 255)) | 8'h01;
      end
      mode_left--;
      case (ready_mode)
        ReadyAlways: out_ready_i <= 1'b1;
        ReadyRandom: out_ready_i <= ($urandom_range(0, 3) != 0);
        default: begin
          out_ready_i <= ready_bits[ready_phase];
          ready_phase = (ready_phase + 1) % 8;
        end
      endcase
    end
  end

  // Offer one character and hold it until accepted. At the end of a burst,
  // drop valid for a random pause; otherwise leave it up for the next item.
  task automatic send_char(input logic [7:0] c, input logic last_c);
    char_code_i <= c;
    last_char_i <= last_c;
    in_valid_i  <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Send a text string, flagging its final character when it closes the string.
  task automatic send_text(input string s, input logic closes);
    for (int i = 0; i < s.len(); i++) send_char(s[i], closes && (i == s.len() - 1));
  endtask

  // Drop valid and wait for a clock edge so the next item starts in a later step.
  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One random string: mostly well-formed groups with random content, some
  // with '=' padding, some broken by a stray byte, some pure noise.
  task automatic send_random_string();
    logic [7:0] text[$];
    int         groups;
    int         tail;
    int         len;
    int         pos;
    if ($urandom_range(0, 5) == 0) begin
      len = $urandom_range(1, 10);
      repeat (len) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      groups = $urandom_range(0, 3);
      tail   = $urandom_range(0, 3);
      if (groups == 0 && tail == 0) tail = $urandom_range(1, 3);
      repeat (4 * groups + tail) text.push_back(alphabet_char($urandom_range(0, 63)));
      if (tail >= 2 && $urandom_range(0, 1) == 1) repeat (4 - tail) text.push_back("=");
      if ($urandom_range(0, 6) == 0) begin
        // Break the sequence with a byte outside the alphabet somewhere.
        pos = $urandom_range(0, text.size() - 1);
        text[pos] = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(128, 255))
                                                 : 8'($urandom_range(0, 42));
      end
    end
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  // Alphabet edges, '+' and '/', padding, early stop, ignored tail,
  // single pending value, bare end markers and codes above 127.
  task automatic test_directed_strings();
    send_text("AZaz09+/", 1'b1);  // two full groups, bytes close the string
    send_text("TQ=x", 1'b1);      // '=' stops decoding, 'x' is ignored
    send_text("Y", 1'b1);         // one pending value yields no byte
    send_text("Ab", 1'b0);
    send_char(8'hff, 1'b0);       // high code stops like '='
    send_char("C", 1'b1);
    send_char(8'h00, 1'b1);       // nothing due: bare end marker
    send_text("//9", 1'b0);
    send_char(8'h80, 1'b1);       // three values pending at the end
    stop_sending();
  endtask

  task automatic test_random_strings();
    int target;
    target = chars_accepted + RandomChars;
    while (chars_accepted < target) send_random_string();
    stop_sending();
  endtask

  // Hold the output off while the sender keeps going, so the queue fills
  // and the input stalls.
  task automatic test_output_hold_off();
    int target;
    target     = chars_accepted + PressureChars;
    burst_left = 1000;
    hold_requests++;
    while (chars_accepted < target) send_random_string();
    burst_left = 0;
    stop_sending();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_strings();
    test_random_strings();
    test_output_hold_off();

    // Drain: wait for every predicted result, then let the pipe settle.
    while (expected_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Decoded %0d strings from %0d characters under input gaps and output stalls",
             strings_closed, chars_accepted);
    $display("Checked %0d data bytes and %0d bare end markers", bytes_checked,
             markers_checked);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_job_fifo.sv
hw/rtl/b64d_back.sv
hw/rtl/base64_stream_decoder.sv
tb/tb_base64_stream_decoder.sv
